>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: beat types, codes and controller/datapath interface.
`default_nettype none

package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int SPQ_CAPACITY = 64;

    // Operation codes.
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_REORDER = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // Memory read address selection.
    localparam logic [1:0] RD_NONE    = 2'd0;
    localparam logic [1:0] RD_HOLE    = 2'd1;
    localparam logic [1:0] RD_HOLE_M1 = 2'd2;
    localparam logic [1:0] RD_HOLE_P1 = 2'd3;

    // Memory write selection.
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_SHIFT = 2'd1;
    localparam logic [1:0] WR_NEW   = 2'd2;

    // Hole pointer operations.
    localparam logic [2:0] HOLE_HOLD = 3'd0;
    localparam logic [2:0] HOLE_CLR  = 3'd1;
    localparam logic [2:0] HOLE_OCC  = 3'd2;
    localparam logic [2:0] HOLE_DEC  = 3'd3;
    localparam logic [2:0] HOLE_INC  = 3'd4;

    // Occupancy operations.
    localparam logic [1:0] OCC_HOLD = 2'd0;
    localparam logic [1:0] OCC_INC  = 2'd1;
    localparam logic [1:0] OCC_DEC  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] priority_req;
        logic [15:0]        tag;
    } spq_in_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_tag;
        logic signed [31:0] out_priority;
        logic [6:0]         count;
    } spq_out_t;

    // One stored queue entry.
    typedef struct packed {
        logic signed [31:0] prio;
        logic [15:0]        tag;
    } spq_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic [2:0] hole_op;
        logic [1:0] occ_op;
        logic       latch_pop;
        logic       set_status;
        logic [1:0] status_code;
        logic       finish;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       hole_zero;
        logic       hole_last;
        logic       shift_dn;
        logic       shift_up;
        logic       tag_hit;
        logic       out_busy;
    } spq_sts_t;

endpackage

`default_nettype wire

>>> rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/spq_dp.sv
// Datapath of the sorted priority queue: item registers, hole pointer, entry memory, result.
`default_nettype none

module spq_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire spq_pkg::spq_in_t  s_data,
    output spq_pkg::spq_out_t      m_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire spq_pkg::spq_cmd_t cmd,
    output spq_pkg::spq_sts_t      sts
);

    import spq_pkg::*;

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);

    spq_in_t            item_reg;
    logic [IDXW-1:0]    hole_reg, hole_next;
    logic [CNTW-1:0]    occ_reg, occ_next;
    logic [1:0]         status_reg;
    logic [15:0]        pop_tag_reg;
    logic signed [31:0] pop_prio_reg;
    spq_out_t           result_reg;
    logic               m_valid_reg;

    logic [IDXW-1:0]    rd_addr;
    logic               rd_en;
    logic               wr_en;
    spq_entry_t         wr_entry;
    spq_entry_t         rd_entry;
    logic [CNTW-1:0]    hole_p1;
    logic [CNTW+6:0]    occ_ext;

    // Entry memory.
    spq_ram #(
        .WIDTH ($bits(spq_entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (hole_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Read address relative to the hole.
    always_comb begin
        rd_en   = (cmd.rd_sel != RD_NONE);
        rd_addr = hole_reg;
        case (cmd.rd_sel)
            RD_HOLE_M1: rd_addr = hole_reg - IDXW'(1);
            RD_HOLE_P1: rd_addr = hole_reg + IDXW'(1);
            default:    rd_addr = hole_reg;
        endcase
    end

    // Write either the entry just read (a shift) or the new entry, always at the hole.
    always_comb begin
        wr_en = (cmd.wr_sel != WR_NONE);
        if (cmd.wr_sel == WR_NEW) begin
            wr_entry.prio = item_reg.priority_req;
            wr_entry.tag  = item_reg.tag;
        end else begin
            wr_entry = rd_entry;
        end
    end

    // Hole pointer and occupancy updates.
    always_comb begin
        hole_next = hole_reg;
        case (cmd.hole_op)
            HOLE_CLR: hole_next = '0;
            HOLE_OCC: hole_next = occ_reg[IDXW-1:0];
            HOLE_DEC: hole_next = hole_reg - IDXW'(1);
            HOLE_INC: hole_next = hole_reg + IDXW'(1);
            default:  hole_next = hole_reg;
        endcase
        occ_next = occ_reg;
        case (cmd.occ_op)
            OCC_INC: occ_next = occ_reg + CNTW'(1);
            OCC_DEC: occ_next = occ_reg - CNTW'(1);
            default: occ_next = occ_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            hole_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg  <= occ_next;
            hole_reg <= hole_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign occ_ext = {7'd0, occ_reg};

    // Item capture, popped entry and result beat.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg     <= s_data;
            status_reg   <= STS_OK;
            pop_tag_reg  <= '0;
            pop_prio_reg <= '0;
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status_code;
            end
            if (cmd.latch_pop) begin
                pop_tag_reg  <= rd_entry.tag;
                pop_prio_reg <= rd_entry.prio;
            end
        end
        if (cmd.finish) begin
            result_reg.status       <= status_reg;
            result_reg.out_tag      <= pop_tag_reg;
            result_reg.out_priority <= pop_prio_reg;
            result_reg.count        <= occ_ext[6:0];
        end
    end

    assign m_data  = result_reg;
    assign m_valid = m_valid_reg;

    // Status towards the controller.
    assign hole_p1 = CNTW'(hole_reg) + CNTW'(1);

    always_comb begin
        sts.op        = item_reg.operation;
        sts.empty     = (occ_reg == '0);
        sts.full      = (occ_reg == CNTW'(CAPACITY));
        sts.hole_zero = (hole_reg == '0);
        sts.hole_last = (hole_p1 >= occ_reg);
        sts.shift_dn  = (rd_entry.prio > item_reg.priority_req);
        sts.shift_up  = (rd_entry.prio < item_reg.priority_req);
        sts.tag_hit   = (rd_entry.tag == item_reg.tag);
        sts.out_busy  = m_valid_reg && !m_ready;
    end

    // The occupancy never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNTW'(CAPACITY))
        else $error("occupancy beyond capacity");

    // Growing the queue only happens while it has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.occ_op == OCC_INC) |-> !sts.full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

>>> rtl/spq_ctrl.sv
// Controller state machine that sequences push, pop and reorder over the entry memory.
`default_nettype none

module spq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t      cmd
);

    import spq_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DISP    = 4'd1;
    localparam logic [3:0] ST_DN_CHK  = 4'd2;
    localparam logic [3:0] ST_DN_EV   = 4'd3;
    localparam logic [3:0] ST_UP_CHK  = 4'd4;
    localparam logic [3:0] ST_UP_EV   = 4'd5;
    localparam logic [3:0] ST_PLACE   = 4'd6;
    localparam logic [3:0] ST_POP_RD  = 4'd7;
    localparam logic [3:0] ST_POP_LAT = 4'd8;
    localparam logic [3:0] ST_POP_CHK = 4'd9;
    localparam logic [3:0] ST_POP_EV  = 4'd10;
    localparam logic [3:0] ST_SRCH_RD = 4'd11;
    localparam logic [3:0] ST_SRCH_EV = 4'd12;
    localparam logic [3:0] ST_FIN     = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.load_item   = 1'b0;
        cmd.rd_sel      = RD_NONE;
        cmd.wr_sel      = WR_NONE;
        cmd.hole_op     = HOLE_HOLD;
        cmd.occ_op      = OCC_HOLD;
        cmd.latch_pop   = 1'b0;
        cmd.set_status  = 1'b0;
        cmd.status_code = STS_OK;
        cmd.finish      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISP;
                end
            end
            ST_DISP: begin
                case (sts.op)
                    OP_PUSH: begin
                        if (sts.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_FULL;
                            state_next      = ST_FIN;
                        end else begin
                            cmd.hole_op = HOLE_OCC;
                            state_next  = ST_DN_CHK;
                        end
                    end
                    OP_POP: begin
                        if (sts.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_EMPTY;
                            state_next      = ST_FIN;
                        end else begin
                            cmd.hole_op = HOLE_CLR;
                            state_next  = ST_POP_RD;
                        end
                    end
                    OP_REORDER: begin
                        if (sts.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STS_NOT_FOUND;
                            state_next      = ST_FIN;
                        end else begin
                            cmd.hole_op = HOLE_CLR;
                            state_next  = ST_SRCH_RD;
                        end
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            // Move the hole towards the front past larger priorities.
            ST_DN_CHK: begin
                if (sts.hole_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.rd_sel = RD_HOLE_M1;
                    state_next = ST_DN_EV;
                end
            end
            ST_DN_EV: begin
                if (sts.shift_dn) begin
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.hole_op = HOLE_DEC;
                    state_next  = ST_DN_CHK;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            // Move the hole towards the back past smaller priorities.
            ST_UP_CHK: begin
                if (sts.hole_last) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.rd_sel = RD_HOLE_P1;
                    state_next = ST_UP_EV;
                end
            end
            ST_UP_EV: begin
                if (sts.shift_up) begin
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.hole_op = HOLE_INC;
                    state_next  = ST_UP_CHK;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.wr_sel = WR_NEW;
                if (sts.op == OP_PUSH) begin
                    cmd.occ_op = OCC_INC;
                end
                state_next = ST_FIN;
            end
            // Pop: read the front, then close the gap one entry at a time.
            ST_POP_RD: begin
                cmd.rd_sel = RD_HOLE;
                state_next = ST_POP_LAT;
            end
            ST_POP_LAT: begin
                cmd.latch_pop = 1'b1;
                state_next    = ST_POP_CHK;
            end
            ST_POP_CHK: begin
                if (sts.hole_last) begin
                    cmd.occ_op = OCC_DEC;
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_sel = RD_HOLE_P1;
                    state_next = ST_POP_EV;
                end
            end
            ST_POP_EV: begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.hole_op = HOLE_INC;
                state_next  = ST_POP_CHK;
            end
            // Reorder: find the first entry with the tag, then pick a direction.
            ST_SRCH_RD: begin
                cmd.rd_sel = RD_HOLE;
                state_next = ST_SRCH_EV;
            end
            ST_SRCH_EV: begin
                if (sts.tag_hit) begin
                    state_next = sts.shift_dn ? ST_DN_CHK : ST_UP_CHK;
                end else if (sts.hole_last) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STS_NOT_FOUND;
                    state_next      = ST_FIN;
                end else begin
                    cmd.hole_op = HOLE_INC;
                    state_next  = ST_SRCH_RD;
                end
            end
            // Hand the result to the output register once it is free.
            ST_FIN: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A result is only loaded when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !sts.out_busy)
        else $error("result overwrites a pending beat");

    // No memory write while waiting for a new beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (cmd.wr_sel == WR_NONE && cmd.occ_op == OCC_HOLD))
        else $error("queue changed while idle");

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller and datapath.
`default_nettype none

// Priority queue of up to CAPACITY entries (signed 32-bit priority, 16-bit tag) kept in
// ascending order in a single-port-read, single-port-write RAM. One beat is handled at a
// time; every beat gives exactly one result beat. The time per beat is set by the memory,
// which moves one entry at a time, each move a read of the neighbour and a write at the
// hole. A push moves every larger entry back by one; a pop reads the front and moves every
// other entry forward; a reorder searches from the front for the tag and then moves the
// entries between its old and new place. A reorder whose tag is absent searches all
// entries. Push on a full queue, pop on an empty one, a reorder on an empty queue and the
// spare operation code finish without touching the memory. The next beat can be accepted
// in the cycle after the result register is loaded. A new beat is accepted while the
// previous result still waits in the output register; the new operation then waits in
// its final state until that result is taken.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire spq_pkg::spq_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output spq_pkg::spq_out_t     m_data
);

    import spq_pkg::*;

    spq_cmd_t cmd;
    spq_sts_t sts;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire
